// File: design/aes_block_cipher_assert.svh
// Assertion macros shared by the cipher RTL.
`ifndef AES_BLOCK_CIPHER_ASSERT_SVH
`define AES_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AES_ASSERT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AES_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// File: design/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Command codes, controller states and the forward and inverse S-box tables.
// ----------------------------------------------------------------------------
package aes_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ENC  = 2'd1,
    CMD_DEC  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_e;

  // Per-step control from the sequencer to the round unit.
  typedef struct packed {
    logic dec;    // inverse cipher
    logic first;  // key addition only
    logic mix;    // apply (Inv)MixColumns
  } round_ctrl_t;

  localparam int unsigned MinRounds = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage

// File: design/aes_keymem.sv
// ----------------------------------------------------------------------------
// AES round-key store
// Synchronous memory, one 128-bit round key per row, written one 32-bit
// column word at a time and read a full row through an output register.
// ----------------------------------------------------------------------------
module aes_keymem #(
  parameter int unsigned ROWS = 15,
  parameter int unsigned RW   = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [RW-1:0] wrow_i,
  input  logic [1:0]    wcol_i,
  input  logic [31:0]   wdata_i,
  input  logic [RW-1:0] raddr_i,
  output logic [127:0]  rdata_o
);

  // Column 0 sits in the top word of a row, matching the block byte order.
  logic [3:0][31:0] mem [ROWS];
  logic [3:0][31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wrow_i][2'd3 - wcol_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/aes_round.sv
// ----------------------------------------------------------------------------
// AES round unit
// One forward or inverse cipher round, or a bare key addition, per cycle.
// ----------------------------------------------------------------------------
module aes_round (
  input  aes_pkg::round_ctrl_t ctrl_i,
  input  logic [127:0]         st_i,
  input  logic [127:0]         key_i,
  output logic [127:0]         st_o
);

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  logic [7:0] s   [16];
  logic [7:0] fw  [16];
  logic [7:0] iv  [16];
  logic [7:0] fm  [16];
  logic [7:0] im  [16];
  logic [7:0] x2  [16];
  logic [7:0] x4  [16];
  logic [7:0] x8  [16];
  logic [127:0] fwd_st, inv_st, fmix_st, imix_st;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st_i[127 - 8*i -: 8];
    end
    // Forward: SubBytes then ShiftRows. Inverse: InvShiftRows then InvSubBytes.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fw[4*c + r] = aes_pkg::SBOX[s[4*((c + r) % 4) + r]];
        iv[4*c + r] = aes_pkg::INV_SBOX[s[4*((c + 4 - r) % 4) + r]];
      end
    end
    for (int i = 0; i < 16; i++) begin
      fwd_st[127 - 8*i -: 8] = fw[i];
      inv_st[127 - 8*i -: 8] = iv[i] ^ key_i[127 - 8*i -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      x2[i] = xt(fw[i]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fm[4*c + r] = x2[4*c + r] ^ x2[4*c + (r + 1) % 4] ^ fw[4*c + (r + 1) % 4]
                    ^ fw[4*c + (r + 2) % 4] ^ fw[4*c + (r + 3) % 4];
      end
    end
    // The inverse mix works on the state after key addition.
    for (int i = 0; i < 16; i++) begin
      im[i] = inv_st[127 - 8*i -: 8];
      x2[i] = xt(im[i]);
      x4[i] = xt(x2[i]);
      x8[i] = xt(x4[i]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        imix_st[127 - 8*(4*c + r) -: 8] =
            (x8[4*c + r] ^ x4[4*c + r] ^ x2[4*c + r])
          ^ (x8[4*c + (r + 1) % 4] ^ x2[4*c + (r + 1) % 4] ^ im[4*c + (r + 1) % 4])
          ^ (x8[4*c + (r + 2) % 4] ^ x4[4*c + (r + 2) % 4] ^ im[4*c + (r + 2) % 4])
          ^ (x8[4*c + (r + 3) % 4] ^ im[4*c + (r + 3) % 4]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      fmix_st[127 - 8*i -: 8] = fm[i];
    end

    priority if (ctrl_i.first) begin
      st_o = st_i ^ key_i;
    end else if (!ctrl_i.dec) begin
      st_o = (ctrl_i.mix ? fmix_st : fwd_st) ^ key_i;
    end else begin
      st_o = ctrl_i.mix ? imix_st : inv_st;
    end
  end

endmodule

// File: design/aes_block_cipher.sv
// A block item is accepted only while the controller is idle; the block then
// runs steps 0..Nr (Nr = 10..14 rounds), one step per round-key row read, and
// its result is registered into the output at the last step, which waits while
// a valid result is stalled. One block is in flight at a time, sharing the single
// key-store read port and round unit. Reset clears the controller and sets the
// round count to 10; the key store is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
// AES block cipher
// Encrypts or decrypts one 128-bit block from round keys held in a store.
// ----------------------------------------------------------------------------
module aes_block_cipher #(
  parameter int unsigned MAX_ROUNDS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  key_index_i,
  input  logic [31:0] key_word_i,
  input  logic [63:0] block_hi_i,
  input  logic [63:0] block_lo_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_hi_o,
  output logic [63:0] out_lo_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);

  `include "aes_block_cipher_assert.svh"

  localparam int unsigned Rows  = MAX_ROUNDS + 1;
  localparam int unsigned RW    = $clog2(Rows);
  localparam int unsigned Words = 4 * Rows;

  aes_pkg::ctrl_state_e state_q, state_d;
  logic [3:0]   rcount_q;
  logic [3:0]   nr_q, nr_d, nr_in;
  logic [3:0]   step_q, step_d;
  logic         dec_q, dec_d;
  logic [127:0] st_q, st_d;
  logic         out_valid_q, out_valid_d;
  logic [127:0] out_q, out_d;

  logic         accept, is_block, key_we, last, out_free;
  logic [3:0]   rd_step;
  logic [RW-1:0] rd_row;
  logic [127:0] key_row, round_st;
  aes_pkg::round_ctrl_t rctrl;

  assign in_stall_o = (state_q != aes_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_block   = (aes_pkg::cmd_e'(cmd_i) == aes_pkg::CMD_ENC)
                   || (aes_pkg::cmd_e'(cmd_i) == aes_pkg::CMD_DEC);
  assign key_we     = accept && (aes_pkg::cmd_e'(cmd_i) == aes_pkg::CMD_LOAD)
                   && ({1'b0, key_index_i} < 7'(Words));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last       = (step_q == nr_q);

  // Out-of-range round counts saturate to the legal range.
  always_comb begin
    priority if (rcount_q < 4'(aes_pkg::MinRounds)) begin
      nr_in = 4'(aes_pkg::MinRounds);
    end else if (rcount_q > 4'(MAX_ROUNDS)) begin
      nr_in = 4'(MAX_ROUNDS);
    end else begin
      nr_in = rcount_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcount_q <= 4'(aes_pkg::MinRounds);
    end else if (cfg_we_i) begin
      rcount_q <= cfg_wdata_i;
    end
  end

  aes_keymem #(
    .ROWS (Rows),
    .RW   (RW)
  ) u_keymem (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .wrow_i  (key_index_i[2 +: RW]),
    .wcol_i  (key_index_i[1:0]),
    .wdata_i (key_word_i),
    .raddr_i (rd_row),
    .rdata_o (key_row)
  );

  assign rctrl.dec   = dec_q;
  assign rctrl.first = (step_q == 4'd0);
  assign rctrl.mix   = (step_q < nr_q);

  aes_round u_round (
    .ctrl_i (rctrl),
    .st_i   (st_q),
    .key_i  (key_row),
    .st_o   (round_st)
  );

  always_comb begin
    state_d     = state_q;
    nr_d        = nr_q;
    step_d      = step_q;
    dec_d       = dec_q;
    st_d        = st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_step     = 4'd0;
    // The read address is issued in the cycle before the step that uses it.
    unique case (state_q)
      aes_pkg::ST_IDLE: begin
        dec_d   = (aes_pkg::cmd_e'(cmd_i) == aes_pkg::CMD_DEC);
        nr_d    = nr_in;
        step_d  = 4'd0;
        st_d    = {block_hi_i, block_lo_i};
        rd_step = 4'd0;
        if (accept && is_block) begin
          state_d = aes_pkg::ST_RUN;
        end
      end
      aes_pkg::ST_RUN: begin
        if (!last || out_free) begin
          st_d    = round_st;
          step_d  = step_q + 4'd1;
          rd_step = step_q + 4'd1;
          if (last) begin
            state_d     = aes_pkg::ST_IDLE;
            out_d       = round_st;
            out_valid_d = 1'b1;
          end
        end else begin
          rd_step = step_q;
        end
      end
      default: begin
        state_d = aes_pkg::ST_IDLE;
      end
    endcase
  end

  // Decryption walks the key rows from the last one down.
  assign rd_row = RW'(dec_d ? (nr_d - rd_step) : rd_step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aes_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nr_q   <= nr_d;
    step_q <= step_d;
    dec_q  <= dec_d;
    st_q   <= st_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_hi_o    = out_q[127:64];
  assign out_lo_o    = out_q[63:0];

  `AES_ASSERT(a_step_range, state_q == aes_pkg::ST_RUN, step_q <= nr_q,
              "round step beyond round count")
  `AES_ASSERT(a_nr_range, state_q == aes_pkg::ST_RUN,
              (nr_q >= 4'(aes_pkg::MinRounds)) && (nr_q <= 4'(MAX_ROUNDS)),
              "round count outside legal range")
  `AES_ASSERT(a_no_load_busy, key_we, state_q == aes_pkg::ST_IDLE,
              "key store written during a block")
  `AES_ASSERT_NEXT(a_done_valid,
                   (state_q == aes_pkg::ST_RUN) && (state_d == aes_pkg::ST_IDLE),
                   out_valid_q, "finished block did not reach the output")

endmodule

// File: test/tb_aes_block_cipher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Drives key loads and encrypt/decrypt blocks under random idling and
// backpressure, and checks every result block against an in-bench cipher.
// ----------------------------------------------------------------------------

class aes_block_board;
  logic [63:0] exp_hi_q[$];
  logic [63:0] exp_lo_q[$];
  int errors = 0;
  int blocks_checked = 0;

  function void note_block(logic [63:0] hi, logic [63:0] lo);
    exp_hi_q.push_back(hi);
    exp_lo_q.push_back(lo);
  endfunction

  function void check_block(logic [63:0] hi, logic [63:0] lo);
    logic [63:0] eh, el;
    if (exp_hi_q.size() == 0) begin
      $display("%0t: unexpected result block %h_%h", $time, hi, lo);
      errors++;
      return;
    end
    eh = exp_hi_q.pop_front();
    el = exp_lo_q.pop_front();
    blocks_checked++;
    if (hi !== eh) begin
      $display("%0t: out_hi mismatch expected %h actual %h", $time, eh, hi);
      errors++;
    end
    if (lo !== el) begin
      $display("%0t: out_lo mismatch expected %h actual %h", $time, el, lo);
      errors++;
    end
  endfunction

  function int pending();
    return exp_hi_q.size();
  endfunction
endclass

module tb_aes_block_cipher;

  localparam int unsigned MaxRounds = 14;
  localparam int unsigned KeyWords = 4 * (MaxRounds + 1);
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = aes_pkg::CMD_NOP;
  logic [5:0]  key_index_i = '0;
  logic [31:0] key_word_i = '0;
  logic [63:0] block_hi_i = '0;
  logic [63:0] block_lo_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] out_hi_o;
  logic [63:0] out_lo_o;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;

  aes_block_cipher #(.MAX_ROUNDS(MaxRounds)) uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  aes_block_board board = new();

  logic [31:0] key_store [KeyWords];
  logic [3:0]  round_reg;
  int          hold_off_cycles = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          enc_count = 0;
  int          dec_count = 0;

  // Cipher helpers: the state is 16 bytes, byte i in column i/4, row i%4.
  typedef logic [7:0] state_t [16];

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = xtime(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] inv_sub(logic [7:0] v);
    for (int k = 0; k < 256; k++)
      if (aes_pkg::SBOX[k] == v) return k[7:0];
    return '0;
  endfunction

  function automatic void add_round_key(ref state_t s, input int rnd);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = key_store[4 * rnd + c];
      for (int r = 0; r < 4; r++) s[4 * c + r] ^= w[31 - 8 * r -: 8];
    end
  endfunction

  function automatic void sub_bytes(ref state_t s, input bit inv);
    for (int i = 0; i < 16; i++) s[i] = inv ? inv_sub(s[i]) : aes_pkg::SBOX[s[i]];
  endfunction

  function automatic void shift_rows(ref state_t s, input bit inv);
    state_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inv) t[4 * ((c + r) % 4) + r] = s[4 * c + r];
        else t[4 * c + r] = s[4 * ((c + r) % 4) + r];
    s = t;
  endfunction

  function automatic void mix_columns(ref state_t s, input bit inv);
    logic [7:0] m [4];
    logic [7:0] col [4];
    logic [7:0] v;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = s[4 * c + k];
      for (int r = 0; r < 4; r++) begin
        v = '0;
        for (int k = 0; k < 4; k++) v ^= gf_mul(col[k], m[(k + 4 - r) % 4]);
        s[4 * c + r] = v;
      end
    end
  endfunction

  function automatic void cipher_block(aes_pkg::cmd_e op, logic [63:0] hi, logic [63:0] lo,
                                       output logic [63:0] res_hi,
                                       output logic [63:0] res_lo);
    state_t s;
    int nr;
    nr = int'(round_reg);
    if (nr < aes_pkg::MinRounds) nr = aes_pkg::MinRounds;
    if (nr > MaxRounds) nr = MaxRounds;
    for (int i = 0; i < 8; i++) begin
      s[i] = hi[63 - 8 * i -: 8];
      s[8 + i] = lo[63 - 8 * i -: 8];
    end
    if (op == aes_pkg::CMD_ENC) begin
      add_round_key(s, 0);
      for (int r = 1; r < nr; r++) begin
        sub_bytes(s, 0);
        shift_rows(s, 0);
        mix_columns(s, 0);
        add_round_key(s, r);
      end
      sub_bytes(s, 0);
      shift_rows(s, 0);
      add_round_key(s, nr);
    end else begin
      add_round_key(s, nr);
      for (int r = nr - 1; r > 0; r--) begin
        shift_rows(s, 1);
        sub_bytes(s, 1);
        add_round_key(s, r);
        mix_columns(s, 1);
      end
      shift_rows(s, 1);
      sub_bytes(s, 1);
      add_round_key(s, 0);
    end
    for (int i = 0; i < 8; i++) begin
      res_hi[63 - 8 * i -: 8] = s[i];
      res_lo[63 - 8 * i -: 8] = s[8 + i];
    end
  endfunction

  // Updates the in-bench key store and queues the expected block.
  function automatic void predict_item(aes_pkg::cmd_e op, logic [5:0] idx,
                                       logic [31:0] word,
                                       logic [63:0] hi, logic [63:0] lo);
    logic [63:0] rh, rl;
    case (op)
      aes_pkg::CMD_LOAD: begin
        if (idx < KeyWords) begin
          key_store[idx] = word;
        end
      end
      aes_pkg::CMD_ENC, aes_pkg::CMD_DEC: begin
        cipher_block(op, hi, lo, rh, rl);
        board.note_block(rh, rl);
        if (op == aes_pkg::CMD_ENC) enc_count++;
        else dec_count++;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_block(out_hi_o, out_lo_o);
  end

  // Receiver stall pattern; a requested hold-off forces a long stall.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Offers one item and holds it until accepted.
  task automatic send_item(aes_pkg::cmd_e op, logic [5:0] idx, logic [31:0] word,
                           logic [63:0] hi, logic [63:0] lo);
    in_valid_i <= 1'b1;
    cmd_i <= op;
    key_index_i <= idx;
    key_word_i <= word;
    block_hi_i <= hi;
    block_lo_i <= lo;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(op, idx, word, hi, lo);
    items_sent++;
  endtask

  task automatic idle_gap(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (MaxRounds + 4) @(posedge clk_i);
  endtask

  task automatic write_rounds(logic [3:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    round_reg = value;
  endtask

  task automatic load_all_keys();
    for (int i = 0; i < KeyWords; i++)
      send_item(aes_pkg::CMD_LOAD, i[5:0], $urandom(), '0, '0);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random items: mostly block operations, some key reloads and noise.
  task automatic random_burst(int count);
    int sel, burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 20));
      end
      burst--;
      sel = $urandom_range(0, 19);
      if (sel < 8) send_item(aes_pkg::CMD_ENC, 6'($urandom()), $urandom(),
                             rand64(), rand64());
      else if (sel < 16) send_item(aes_pkg::CMD_DEC, 6'($urandom()), $urandom(),
                                   rand64(), rand64());
      else if (sel < 18) send_item(aes_pkg::CMD_LOAD, 6'($urandom_range(0, KeyWords - 1)),
                                   $urandom(), rand64(), rand64());
      else if (sel < 19) send_item(aes_pkg::CMD_LOAD, 6'($urandom_range(KeyWords, 63)),
                                   $urandom(), rand64(), rand64());
      else send_item(aes_pkg::CMD_NOP, 6'($urandom()), $urandom(), rand64(), rand64());
    end
  endtask

  logic [3:0] round_settings [6] = '{4'd10, 4'd12, 4'd14, 4'd11, 4'd0, 4'd15};

  initial begin
    round_reg = 4'd10;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset round count, field extremes, every command.
    load_all_keys();
    send_item(aes_pkg::CMD_ENC, '0, '0, '0, '0);
    send_item(aes_pkg::CMD_DEC, '1, '1, '1, '1);
    send_item(aes_pkg::CMD_ENC, '1, '1, '1, '1);
    send_item(aes_pkg::CMD_DEC, '0, '0, '0, '0);
    send_item(aes_pkg::CMD_LOAD, 6'd63, 32'hffff_ffff, '0, '0);
    send_item(aes_pkg::CMD_LOAD, KeyWords[5:0], 32'h0, '1, '1);
    send_item(aes_pkg::CMD_NOP, '1, '1, '1, '1);
    send_item(aes_pkg::CMD_LOAD, 6'd0, 32'h0, '0, '0);
    send_item(aes_pkg::CMD_LOAD, KeyWords[5:0] - 6'd1, 32'hffff_ffff, '0, '0);
    send_item(aes_pkg::CMD_ENC, '0, '0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_item(aes_pkg::CMD_DEC, '0, '0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);

    // Long receiver hold-off while blocks keep coming, so the input stalls.
    hold_off_cycles = 200;
    for (int i = 0; i < 12; i++) send_item(aes_pkg::CMD_ENC, '0, '0, rand64(), rand64());
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_rounds(round_settings[p]);
      if (p == 3) load_all_keys();
      random_burst(125);
      // Sender pause until every block is back before the next setting.
      wait_drained();
    end

    wait_drained();
    $display("Covered %0d items: %0d encrypts, %0d decrypts, %0d blocks checked,",
             items_sent, enc_count, dec_count, board.blocks_checked);
    $display("round counts 10, 11, 12 and 14 plus out-of-range values, and key reloads.");
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
